// File: hdl/upr_pkg.sv
package upr_pkg;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd2;

    // Register widths
    localparam int SCALE_W = 4;
    localparam int SRC_WIDTH_W = 12;
    localparam int SRC_HEIGHT_W = 13;
    localparam int ROW_W = 12;
    localparam int PIX_W = 24;

    // Item commands
    localparam logic CMD_PIXEL  = 1'b0;
    localparam logic CMD_REPLAY = 1'b1;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // Work descriptor handed from the front end to the back end
    typedef struct packed {
        logic               err;
        logic               replay;
        logic [PIX_W-1:0]   pix;
        logic [SCALE_W-1:0] last_k;
        logic               row_end;
        logic               frame_end;
        logic [1:0]         pad;
    } t_desc;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       last_copy;
        logic       row_end;
        logic       frame_end;
        logic [1:0] pad_bytes;
        logic       phase_error;
    } t_out_item;

endpackage

// File: hdl/upr_in_if.sv
interface upr_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;

    modport source (output valid, output cmd, output blue_in, output green_in,
                    output red_in, input ready);
    modport sink   (input valid, input cmd, input blue_in, input green_in,
                    input red_in, output ready);
endinterface

// File: hdl/upr_out_if.sv
interface upr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       last_copy;
    logic       row_end;
    logic       frame_end;
    logic [1:0] pad_bytes;
    logic       phase_error;

    modport source (output valid, output blue_out, output green_out, output red_out,
                    output last_copy, output row_end, output frame_end,
                    output pad_bytes, output phase_error, input ready);
    modport sink   (input valid, input blue_out, input green_out, input red_out,
                    input last_copy, input row_end, input frame_end,
                    input pad_bytes, input phase_error, output ready);
endinterface

// File: hdl/upr_ram.sv
module upr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/upr_front.sv
module upr_front #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_SCALE = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  upr_pkg::t_cfg_wr i_cfg,
    upr_in_if.sink         i_src,
    output logic           o_push_valid,
    output upr_pkg::t_desc o_push_desc,
    input  logic           i_push_ready
);
    import upr_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);

    // Configuration registers
    logic [SCALE_W-1:0]      r_scale;
    logic [SRC_WIDTH_W-1:0]  r_src_width;
    logic [SRC_HEIGHT_W-1:0] r_src_height;

    // Raster position
    logic [XW-1:0]      r_col, n_col;
    logic [SCALE_W-1:0] r_pass, n_pass;
    logic [ROW_W-1:0]   r_row, n_row;

    // Descriptor stage, aligned with the line store read data
    logic  r_dv, n_dv;
    t_desc r_desc, n_desc;

    logic [SCALE_W-1:0] s_m1;
    logic [XW-1:0]      w_m1;
    logic [ROW_W-1:0]   h_m1;
    logic [3:0]         pad_prod;
    logic               accept;
    logic               err;
    logic               row_done;
    logic               pass_done;
    logic               frame_done;
    logic               ram_we;
    logic               ram_re;
    logic [PIX_W-1:0]   ram_rdata;
    logic [PIX_W-1:0]   in_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale      <= SCALE_W'(1);
            r_src_width  <= SRC_WIDTH_W'(1);
            r_src_height <= SRC_HEIGHT_W'(1);
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                CFG_SCALE:      r_scale      <= i_cfg.data[SCALE_W-1:0];
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg.data[SRC_WIDTH_W-1:0];
                CFG_SRC_HEIGHT: r_src_height <= i_cfg.data[SRC_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamped limits, kept as limit minus one
    always_comb begin
        if (r_scale == '0) begin
            s_m1 = '0;
        end else if (32'(r_scale) > MAX_SCALE) begin
            s_m1 = SCALE_W'(MAX_SCALE - 1);
        end else begin
            s_m1 = r_scale - SCALE_W'(1);
        end

        if (r_src_width == '0) begin
            w_m1 = '0;
        end else if (32'(r_src_width) > MAX_WIDTH) begin
            w_m1 = XW'(MAX_WIDTH - 1);
        end else begin
            w_m1 = XW'(32'(r_src_width) - 32'd1);
        end

        if (r_src_height == '0) begin
            h_m1 = '0;
        end else begin
            h_m1 = r_src_height[SRC_HEIGHT_W-1] ? '1 : ROW_W'(r_src_height - 13'd1);
        end
    end

    // Output row width mod 4 needs only the low bits of width and scale
    assign pad_prod = {2'b00, w_m1[1:0] + 2'd1} * {2'b00, s_m1[1:0] + 2'd1};

    // Classify the item against the expected phase
    assign accept     = i_src.valid && i_src.ready;
    assign err        = (i_src.cmd == CMD_REPLAY) != (r_pass != '0);
    assign row_done   = r_col >= w_m1;
    assign pass_done  = row_done && (r_pass >= s_m1);
    assign frame_done = pass_done && (r_row >= h_m1);
    assign in_pix     = {i_src.red_in, i_src.green_in, i_src.blue_in};

    assign ram_we = accept && !err && (i_src.cmd == CMD_PIXEL);
    assign ram_re = accept && !err && (i_src.cmd == CMD_REPLAY);

    upr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_col),
        .i_wdata (in_pix),
        .i_re    (ram_re),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_col  = r_col;
        n_pass = r_pass;
        n_row  = r_row;
        n_dv   = r_dv;
        n_desc = r_desc;

        if (o_push_valid && i_push_ready) begin
            n_dv = 1'b0;
        end

        if (accept) begin
            n_dv = 1'b1;
            n_desc.err       = err;
            n_desc.replay    = !err && (i_src.cmd == CMD_REPLAY);
            n_desc.pix       = (err || i_src.cmd == CMD_REPLAY) ? '0 : in_pix;
            n_desc.last_k    = err ? '0 : s_m1;
            n_desc.row_end   = !err && row_done;
            n_desc.frame_end = !err && frame_done;
            n_desc.pad       = (!err && row_done) ? pad_prod[1:0] : 2'd0;

            // Advance column, pass and row
            if (!err) begin
                if (row_done) begin
                    n_col = '0;
                    if (pass_done) begin
                        n_pass = '0;
                        n_row  = frame_done ? '0 : r_row + ROW_W'(1);
                    end else begin
                        n_pass = r_pass + SCALE_W'(1);
                    end
                end else begin
                    n_col = r_col + XW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_pass <= '0;
            r_row  <= '0;
            r_dv   <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_pass <= n_pass;
            r_row  <= n_row;
            r_dv   <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_desc <= n_desc;
    end

    // Stage frees up when its descriptor moves into the queue
    assign i_src.ready = !r_dv || i_push_ready;

    always_comb begin
        o_push_desc = r_desc;
        if (r_desc.replay) begin
            o_push_desc.pix = ram_rdata;
        end
    end

    assign o_push_valid = r_dv;
endmodule

// File: hdl/upr_fifo.sv
module upr_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  upr_pkg::t_desc i_push_desc,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output upr_pkg::t_desc o_pop_desc,
    input  logic           i_pop
);
    import upr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_desc          r_mem [DEPTH];
    logic [AW-1:0]  r_wp, n_wp;
    logic [AW-1:0]  r_rp, n_rp;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           push;
    logic           pop;

    assign o_push_ready = r_cnt != CW'(DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_desc   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    // Pointer and fill count update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (32'(r_wp) == DEPTH - 1) ? '0 : r_wp + AW'(1);
        end
        if (pop) begin
            n_rp = (32'(r_rp) == DEPTH - 1) ? '0 : r_rp + AW'(1);
        end
        case ({push, pop})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_desc;
        end
    end
endmodule

// File: hdl/upr_back.sv
module upr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_desc_valid,
    input  upr_pkg::t_desc i_desc,
    output logic           o_pop,
    upr_out_if.source      o_dst
);
    import upr_pkg::*;

    logic [SCALE_W-1:0] r_k, n_k;
    logic               r_ov, n_ov;
    t_out_item          r_out, n_out;
    logic               emit;
    logic               last;

    // One copy per cycle while the output register is free or draining
    assign emit  = i_desc_valid && (!r_ov || o_dst.ready);
    assign last  = r_k == i_desc.last_k;
    assign o_pop = emit && last;

    always_comb begin
        n_k   = r_k;
        n_ov  = r_ov;
        n_out = r_out;
        if (o_dst.ready) begin
            n_ov = 1'b0;
        end
        if (emit) begin
            n_ov              = 1'b1;
            n_k               = last ? '0 : r_k + SCALE_W'(1);
            n_out.blue        = i_desc.pix[7:0];
            n_out.green       = i_desc.pix[15:8];
            n_out.red         = i_desc.pix[23:16];
            n_out.last_copy   = last;
            n_out.row_end     = last && i_desc.row_end;
            n_out.frame_end   = last && i_desc.frame_end;
            n_out.pad_bytes   = last ? i_desc.pad : 2'd0;
            n_out.phase_error = i_desc.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k  <= '0;
            r_ov <= 1'b0;
        end else begin
            r_k  <= n_k;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_dst.valid       = r_ov;
    assign o_dst.blue_out    = r_out.blue;
    assign o_dst.green_out   = r_out.green;
    assign o_dst.red_out     = r_out.red;
    assign o_dst.last_copy   = r_out.last_copy;
    assign o_dst.row_end     = r_out.row_end;
    assign o_dst.frame_end   = r_out.frame_end;
    assign o_dst.pad_bytes   = r_out.pad_bytes;
    assign o_dst.phase_error = r_out.phase_error;
endmodule

// File: hdl/pixel_replication_upscaler.sv
// Channel    Dir  Handshake      Payload
// i_src      in   valid/ready    cmd, blue_in, green_in, red_in
// o_dst      out  valid/ready    blue_out, green_out, red_out, last_copy, row_end,
//                                frame_end, pad_bytes, phase_error
// i_cfg_*    in   write enable   i_cfg_idx selects scale, src_width, src_height
//
// The front end takes one item per cycle, unless the queue is full, into a descriptor
// stage and a 2-entry queue. The back end sends one pixel per cycle while o_dst is ready,
// so an item yields scale copies (1 to MAX_SCALE); a phase error yields one. The sustained
// rate is set by o_dst. Replay pixels come from the line store. Synchronous active-low
// reset clears counters, queue and output valid and sets every configuration register to
// 1; the line store is not cleared. Either side may stall independently.
module pixel_replication_upscaler #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_SCALE = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [upr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [upr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    upr_in_if.sink                            i_src,
    upr_out_if.source                         o_dst
);
    import upr_pkg::*;

    t_cfg_wr cfg;
    logic    push_valid;
    t_desc   push_desc;
    logic    push_ready;
    logic    pop_valid;
    t_desc   pop_desc;
    logic    pop;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    upr_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_src        (i_src),
        .o_push_valid (push_valid),
        .o_push_desc  (push_desc),
        .i_push_ready (push_ready)
    );

    upr_fifo #(
        .DEPTH (2)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_desc  (push_desc),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_desc   (pop_desc),
        .i_pop        (pop)
    );

    upr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (pop_valid),
        .i_desc       (pop_desc),
        .o_pop        (pop),
        .o_dst        (o_dst)
    );
endmodule
